[rtl/jdc_pkg.sv]
package jdc_pkg;

   // field widths
   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int SECS_W  = 17;
   localparam int JD_W    = 23;

   // commands
   localparam logic CMD_TO_JD  = 1'b0;
   localparam logic CMD_TO_CAL = 1'b1;

   // limits and epochs
   localparam logic [SECS_W-1:0] SEC_MAX      = 17'd86399;
   localparam logic [SECS_W-1:0] SEC_PER_DAY  = 17'd86400;
   localparam logic [SECS_W-1:0] HALF_DAY     = 17'd43200;
   localparam logic [JD_W-1:0]   JD_MIN       = 23'd1721424;
   localparam logic [JD_W-1:0]   JD_MAX       = 23'd5373484;
   localparam logic [JD_W-1:0]   GREG_JD      = 23'd2299161;
   localparam logic [JD_W-1:0]   JD_BASE      = 23'd1720994;
   localparam logic [YEAR_W-1:0] YEAR_MAX     = 14'd9999;

   // hour/minute/second split
   localparam logic [5:0]  HOUR_RECIP = 6'd36;   // 2^17 / 3600
   localparam logic [6:0]  MIN_RECIP  = 7'd68;   // 2^12 / 60
   localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
   localparam logic [5:0]  SEC_PER_MIN  = 6'd60;

   // floor(30.6001 * k)
   localparam logic [8:0] MTAB [16] = '{
      9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd153, 9'd183, 9'd214,
      9'd244, 9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459};

   // ceil(30.6001 * k), first entry unused
   localparam logic [8:0] ETHR_TAB [16] = '{
      9'd0,   9'd31,  9'd62,  9'd92,  9'd123, 9'd154, 9'd184, 9'd215,
      9'd245, 9'd276, 9'd307, 9'd337, 9'd368, 9'd398, 9'd429, 9'd460};

   // fields riding along the pipe
   typedef struct packed {
      logic              cmd;
      logic              greg;
      logic              over;
      logic [JD_W-1:0]   jd_out;
      logic [SECS_W-1:0] js_out;
      logic [YEAR_W-1:0] yr;
      logic [MONTH_W-1:0] mo;
      logic [DAY_W-1:0]  dy;
      logic [SECS_W-1:0] secs;
   } carry_type;

endpackage

[rtl/jdc_hms.sv]
module jdc_hms
   import jdc_pkg::*;
(
   input  logic              clock,
   input  logic [SECS_W-1:0] secs,
   output logic [4:0]        hour,
   output logic [5:0]        minute,
   output logic [5:0]        second
);

   logic [SECS_W-1:0] h1_secs_ff;
   logic [4:0]        h1_hest_ff;
   logic [22:0]       h1_prod;
   logic [4:0]        h2_hour_ff, h2_hour_in;
   logic [11:0]       h2_rem_ff, h2_rem_in;
   logic [16:0]       h2_sub;
   logic [16:0]       h2_diff;
   logic [4:0]        h3_hour_ff;
   logic [11:0]       h3_rem_ff;
   logic [5:0]        h3_mest_ff;
   logic [18:0]       h3_prod;
   logic [11:0]       h4_sub;
   logic [11:0]       h4_diff;
   logic [4:0]        h4_hour_ff;
   logic [5:0]        h4_min_ff, h4_min_in;
   logic [5:0]        h4_sec_ff, h4_sec_in;

   // hour estimate by reciprocal, may be one low
   assign h1_prod = 23'(secs) * 23'(HOUR_RECIP);

   always_ff @(posedge clock) begin
      h1_secs_ff <= secs;
      h1_hest_ff <= h1_prod[21:17];
   end

   always_comb begin
      h2_sub  = 17'(h1_hest_ff) * 17'(SEC_PER_HOUR);
      h2_diff = h1_secs_ff - h2_sub;
      if (h2_diff >= 17'(SEC_PER_HOUR)) begin
         h2_hour_in = h1_hest_ff + 5'd1;
         h2_rem_in  = 12'(h2_diff - 17'(SEC_PER_HOUR));
      end else begin
         h2_hour_in = h1_hest_ff;
         h2_rem_in  = 12'(h2_diff);
      end
   end

   always_ff @(posedge clock) begin
      h2_hour_ff <= h2_hour_in;
      h2_rem_ff  <= h2_rem_in;
   end

   assign h3_prod = 19'(h2_rem_ff) * 19'(MIN_RECIP);

   always_ff @(posedge clock) begin
      h3_hour_ff <= h2_hour_ff;
      h3_rem_ff  <= h2_rem_ff;
      h3_mest_ff <= h3_prod[17:12];
   end

   always_comb begin
      h4_sub  = 12'(h3_mest_ff) * 12'(SEC_PER_MIN);
      h4_diff = h3_rem_ff - h4_sub;
      if (h4_diff >= 12'(SEC_PER_MIN)) begin
         h4_min_in = h3_mest_ff + 6'd1;
         h4_sec_in = 6'(h4_diff - 12'(SEC_PER_MIN));
      end else begin
         h4_min_in = h3_mest_ff;
         h4_sec_in = 6'(h4_diff);
      end
   end

   always_ff @(posedge clock) begin
      h4_hour_ff <= h3_hour_ff;
      h4_min_ff  <= h4_min_in;
      h4_sec_ff  <= h4_sec_in;
   end

   assign hour   = h4_hour_ff;
   assign minute = h4_min_ff;
   assign second = h4_sec_ff;

endmodule

[rtl/julian_date_converter.sv]
// julian day converter, calendar date/time <-> julian day number and seconds
//
// request channel: drive the req_ fields and pulse start; a request is taken
// at every rising edge with start high and busy low. busy stays low, so a new
// request may be issued every cycle, mixing both commands freely.
// req_command 0 converts year/month/day/seconds to a julian day, 1 converts a
// julian day and seconds since noon back to a calendar date and time.
// out-of-range inputs are saturated to their legal ranges first.
//
// result channel: each result shows on the rsp_ ports for one cycle with
// rsp_valid high, in request order. the receiver cannot hold results off, so
// nothing is buffered.
//
// throughput is one request per clock; the pipeline depth is set by the
// julian-to-calendar path: two reciprocal divides (alpha and year count),
// each a multiply stage and a correction stage, then the month search.
//
// synchronous reset clears the valid bits only; requests in flight are lost.
module julian_date_converter
   import jdc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_command,
   input  logic [YEAR_W-1:0]  req_year,
   input  logic [MONTH_W-1:0] req_month,
   input  logic [DAY_W-1:0]   req_day_of_month,
   input  logic [SECS_W-1:0]  req_seconds_of_day,
   input  logic [JD_W-1:0]    req_julian_day,
   input  logic [SECS_W-1:0]  req_julian_seconds,
   output logic               rsp_valid,
   output logic [JD_W-1:0]    rsp_out_julian_day,
   output logic [SECS_W-1:0]  rsp_out_julian_seconds,
   output logic [YEAR_W-1:0]  rsp_out_year,
   output logic [MONTH_W-1:0] rsp_out_month,
   output logic [DAY_W-1:0]   rsp_out_day,
   output logic [4:0]         rsp_out_hour,
   output logic [5:0]         rsp_out_minute,
   output logic [5:0]         rsp_out_second,
   output logic               rsp_gregorian
);

   // valid bits and fields riding along
   logic [9:1]   v_ff, v_in;
   carry_type    car_ff [1:8];
   carry_type    car_in [1:8];

   // saturated inputs
   logic [YEAR_W-1:0]  y_c;
   logic [MONTH_W-1:0] m_c;
   logic [DAY_W-1:0]   d_c;
   logic [SECS_W-1:0]  s_c, t_c;
   logic [JD_W-1:0]    z_c;

   // stage 1 logic
   logic               jan_feb;
   logic [YEAR_W-1:0]  ys;
   logic [MONTH_W-1:0] ms;
   logic               greg_c;
   logic [SECS_W-1:0]  s_h, s_j, t_h, t_j;
   logic               wrap_c, wrap_j;
   logic [JD_W-1:0]    z2;
   logic               over_j, greg_j;
   logic [21:0]        a_prod;

   // calendar-to-julian path
   logic [YEAR_W-1:0]  c1_ys_ff;
   logic [MONTH_W-1:0] c1_ms_ff;
   logic [DAY_W-1:0]   c1_d_ff;
   logic [24:0]        c1_p_ff;
   logic [6:0]         c1_aest_ff;
   logic               c1_wrap_ff;
   logic [YEAR_W-1:0]  c2_chk;
   logic [6:0]         c2_a_ff, c2_a_in;
   logic [JD_W-1:0]    c2_jdb_ff, c2_jdb_in;
   logic [JD_W-1:0]    c3_jd;

   // julian-to-calendar path
   logic [JD_W-1:0]    j1_z2_ff, j2_z2_ff, j3_z2_ff;
   logic               j1_greg_ff, j2_greg_ff, j3_greg_ff;
   logic [23:0]        j1_nal_ff, j2_nal_ff;
   logic [30:0]        j1_alprod;
   logic [6:0]         j2_alest_ff;
   logic [24:0]        j2_chk;
   logic [6:0]         j3_alpha_ff, j3_alpha_in;
   logic [JD_W-1:0]    j4_b_ff, j4_b_in;
   logic [26:0]        j4_cn_ff, j4_cn_in;
   logic [41:0]        j4_cprod;
   logic [JD_W-1:0]    j5_b_ff;
   logic [26:0]        j5_cn_ff;
   logic [13:0]        j5_cest_ff;
   logic [26:0]        j5_chk;
   logic [JD_W-1:0]    j6_b_ff;
   logic [13:0]        j6_c_ff, j6_c_in;
   logic [24:0]        j6_dd;
   logic [JD_W-1:0]    j6_x;
   logic [8:0]         j7_x_ff;
   logic [13:0]        j7_c_ff;
   logic [3:0]         j7_e;
   logic [8:0]         j8_x_ff;
   logic [13:0]        j8_c_ff;
   logic [3:0]         j8_e_ff;

   // output stage
   logic [JD_W-1:0]    o_jd_ff;
   logic [SECS_W-1:0]  o_js_ff;
   logic [YEAR_W-1:0]  o_yr_ff, o_yr_in;
   logic [MONTH_W-1:0] o_mo_ff, o_mo_in;
   logic [DAY_W-1:0]   o_dy_ff, o_dy_in;
   logic               o_greg_ff;
   logic [MONTH_W-1:0] j_mo;

   assign busy = 1'b0;

   // saturate the request fields
   always_comb begin
      y_c = (req_year == '0) ? 14'd1 : ((req_year > YEAR_MAX) ? YEAR_MAX : req_year);
      m_c = (req_month == '0) ? 4'd1 : ((req_month > 4'd12) ? 4'd12 : req_month);
      d_c = (req_day_of_month == '0) ? 5'd1 : req_day_of_month;
      s_c = (req_seconds_of_day > SEC_MAX) ? SEC_MAX : req_seconds_of_day;
      t_c = (req_julian_seconds > SEC_MAX) ? SEC_MAX : req_julian_seconds;
      z_c = (req_julian_day < JD_MIN) ? JD_MIN :
            ((req_julian_day > JD_MAX) ? JD_MAX : req_julian_day);
   end

   // stage 1: year shift, gregorian tests, noon shift of the time of day
   always_comb begin
      jan_feb = (m_c < 4'd3);
      ys      = y_c - 14'(jan_feb);
      ms      = jan_feb ? m_c + 4'd12 : m_c;
      // 1582-10-15 onward, compared field by field
      greg_c  = (ys > 14'd1582) ||
                ((ys == 14'd1582) && ((ms > 4'd10) || ((ms == 4'd10) && (d_c >= 5'd15))));
      s_h     = s_c + HALF_DAY;
      wrap_c  = (s_h >= SEC_PER_DAY);
      s_j     = wrap_c ? s_h - SEC_PER_DAY : s_h;
      t_h     = t_c + HALF_DAY;
      wrap_j  = (t_h >= SEC_PER_DAY);
      t_j     = wrap_j ? t_h - SEC_PER_DAY : t_h;
      z2      = z_c + 23'(wrap_j);
      over_j  = (z2 > JD_MAX);
      greg_j  = (z2 >= GREG_JD);
      a_prod  = 22'(ys) * 22'd163;   // ys / 100 estimate, 2^14 scale
   end

   // carried fields
   always_comb begin
      v_in[1] = start;
      car_in[1].cmd    = req_command;
      car_in[1].greg   = req_command ? (over_j | greg_j) : greg_c;
      car_in[1].over   = over_j;
      car_in[1].jd_out = req_command ? z_c : '0;
      car_in[1].js_out = req_command ? t_c : s_j;
      car_in[1].yr     = y_c;
      car_in[1].mo     = m_c;
      car_in[1].dy     = d_c;
      car_in[1].secs   = req_command ? (over_j ? SEC_MAX : t_j) : s_c;
      for (int k = 2; k <= 8; k++) begin
         car_in[k] = car_ff[k-1];
      end
      for (int k = 2; k <= 9; k++) begin
         v_in[k] = v_ff[k-1];
      end
      if (!car_ff[2].cmd) begin
         car_in[3].jd_out = c3_jd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 1; k <= 8; k++) begin
         car_ff[k] <= car_in[k];
      end
   end

   // calendar-to-julian, stages 1 to 3
   always_ff @(posedge clock) begin
      c1_ys_ff   <= ys;
      c1_ms_ff   <= ms;
      c1_d_ff    <= d_c;
      c1_p_ff    <= 25'(ys) * 25'd1461;
      c1_aest_ff <= a_prod[20:14];
      c1_wrap_ff <= wrap_c;
   end

   always_comb begin
      c2_chk    = c1_ys_ff - 14'(c1_aest_ff) * 14'd100;
      c2_a_in   = c1_aest_ff + 7'(c2_chk >= 14'd100);
      c2_jdb_in = JD_BASE + 23'(c1_p_ff >> 2) + 23'(MTAB[c1_ms_ff + 4'd1])
                  + 23'(c1_d_ff) + 23'(c1_wrap_ff);
   end

   always_ff @(posedge clock) begin
      c2_a_ff   <= c2_a_in;
      c2_jdb_ff <= c2_jdb_in;
   end

   // gregorian correction 2 - a + a/4
   assign c3_jd = car_ff[2].greg ?
                  c2_jdb_ff + 23'd2 - 23'(c2_a_ff) + 23'(c2_a_ff >> 2) : c2_jdb_ff;

   // julian-to-calendar, alpha by reciprocal of 146097 at 2^24 scale
   always_ff @(posedge clock) begin
      j1_z2_ff   <= z2;
      j1_greg_ff <= greg_j;
      j1_nal_ff  <= greg_j ? (24'(z2) << 2) - 24'd7468865 : '0;
   end

   assign j1_alprod = 31'(j1_nal_ff) * 31'd114;

   always_ff @(posedge clock) begin
      j2_z2_ff    <= j1_z2_ff;
      j2_greg_ff  <= j1_greg_ff;
      j2_nal_ff   <= j1_nal_ff;
      j2_alest_ff <= j1_alprod[30:24];
   end

   always_comb begin
      j2_chk      = 25'(j2_nal_ff) - 25'(j2_alest_ff) * 25'd146097;
      j3_alpha_in = j2_alest_ff + 7'(j2_chk >= 25'd146097);
   end

   always_ff @(posedge clock) begin
      j3_z2_ff    <= j2_z2_ff;
      j3_greg_ff  <= j2_greg_ff;
      j3_alpha_ff <= j3_alpha_in;
   end

   always_comb begin
      j4_b_in  = (j3_greg_ff ?
                  j3_z2_ff + 23'd1 + 23'(j3_alpha_ff) - 23'(j3_alpha_ff >> 2) : j3_z2_ff)
                 + 23'd1524;
      j4_cn_in = (27'(j4_b_in) << 4) + (27'(j4_b_in) << 2) - 27'd2442;
   end

   always_ff @(posedge clock) begin
      j4_b_ff  <= j4_b_in;
      j4_cn_ff <= j4_cn_in;
   end

   // year count c = cn / 7305, reciprocal at 2^27 scale
   assign j4_cprod = 42'(j4_cn_ff) * 42'd18373;

   always_ff @(posedge clock) begin
      j5_b_ff    <= j4_b_ff;
      j5_cn_ff   <= j4_cn_ff;
      j5_cest_ff <= j4_cprod[40:27];
   end

   always_comb begin
      j5_chk  = j5_cn_ff - 27'(j5_cest_ff) * 27'd7305;
      j6_c_in = j5_cest_ff + 14'(j5_chk >= 27'd7305);
   end

   always_ff @(posedge clock) begin
      j6_b_ff <= j5_b_ff;
      j6_c_ff <= j6_c_in;
   end

   // days into the shifted year
   always_comb begin
      j6_dd = 25'(j6_c_ff) * 25'd1461;
      j6_x  = j6_b_ff - 23'(j6_dd >> 2);
   end

   always_ff @(posedge clock) begin
      j7_x_ff <= 9'(j6_x);
      j7_c_ff <= j6_c_ff;
   end

   // month index e = x / 30.6001 by threshold count
   always_comb begin
      j7_e = '0;
      for (int k = 1; k < 16; k++) begin
         j7_e = j7_e + 4'(j7_x_ff >= ETHR_TAB[k]);
      end
   end

   always_ff @(posedge clock) begin
      j8_x_ff <= j7_x_ff;
      j8_c_ff <= j7_c_ff;
      j8_e_ff <= j7_e;
   end

   // output stage
   always_comb begin
      j_mo = (j8_e_ff < 4'd14) ? j8_e_ff - 4'd1 : j8_e_ff - 4'd13;
      if (!car_ff[8].cmd) begin
         o_yr_in = car_ff[8].yr;
         o_mo_in = car_ff[8].mo;
         o_dy_in = car_ff[8].dy;
      end else if (car_ff[8].over) begin
         o_yr_in = YEAR_MAX;
         o_mo_in = 4'd12;
         o_dy_in = 5'd31;
      end else begin
         o_yr_in = (j_mo > 4'd2) ? j8_c_ff - 14'd4716 : j8_c_ff - 14'd4715;
         o_mo_in = j_mo;
         o_dy_in = 5'(j8_x_ff - MTAB[j8_e_ff]);
      end
   end

   always_ff @(posedge clock) begin
      o_jd_ff   <= car_ff[8].jd_out;
      o_js_ff   <= car_ff[8].js_out;
      o_yr_ff   <= o_yr_in;
      o_mo_ff   <= o_mo_in;
      o_dy_ff   <= o_dy_in;
      o_greg_ff <= car_ff[8].greg;
   end

   // time of day split, stages 6 to 9
   jdc_hms u_hms (
      .clock  (clock),
      .secs   (car_ff[5].secs),
      .hour   (rsp_out_hour),
      .minute (rsp_out_minute),
      .second (rsp_out_second)
   );

   assign rsp_valid              = v_ff[9];
   assign rsp_out_julian_day     = o_jd_ff;
   assign rsp_out_julian_seconds = o_js_ff;
   assign rsp_out_year           = o_yr_ff;
   assign rsp_out_month          = o_mo_ff;
   assign rsp_out_day            = o_dy_ff;
   assign rsp_gregorian          = o_greg_ff;

`ifndef ASSERT_OFF
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##9 rsp_valid)
      else $error("request did not come out after nine cycles");

   a_month: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_month >= 4'd1) && (rsp_out_month <= 4'd12))
      else $error("month out of range");

   a_hms: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_hour < 5'd24) && (rsp_out_minute < 6'd60)
                    && (rsp_out_second < 6'd60))
      else $error("time of day split out of range");

   a_jsecs: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_julian_seconds < SEC_PER_DAY))
      else $error("julian seconds out of range");
`endif

endmodule
